[sv/dte_pkg.sv]
// Shared types, constants and month tables for the date to weekday and epoch pipeline.
// Used by every stage module and by the top level; depends on nothing else.
`timescale 1ns / 1ps

package dte_pkg;

    localparam int YEAR_W = 25;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int SEC_W  = 50;
    localparam int DAYS_W = 34;
    localparam int QY_W   = 19;
    localparam int PROD_W = 51;
    localparam int MOFF_W = 9;

    localparam logic [YEAR_W-1:0] YEAR_MIN  = 25'd1970;
    localparam logic [YEAR_W-1:0] YEAR_MAX  = 25'd30000000;
    localparam logic [MON_W-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0]  MONTH_DEC = 4'd12;

    // floor(y / 100) = (y * ceil(2^32 / 100)) >> 32, exact for y below 2^30.
    localparam logic [25:0] DIV100_MUL   = 26'd42949673;
    localparam int          DIV100_SHIFT = 32;
    localparam logic [6:0]  CENTURY      = 7'd100;

    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR    = 34'd365;
    localparam logic [DAYS_W-1:0] EPOCH_DAY_OFFSET = 34'd719468;

    // 86400 = 675 * 2^7.
    localparam logic [9:0] SEC_MUL   = 10'd675;
    localparam int         SEC_SHIFT = 7;

    typedef struct packed {
        logic              valid;
        logic              pre_ok;
        logic              early;
        logic              feb;
        logic [YEAR_W-1:0] year;
        logic [PROD_W-1:0] prod;
        logic [MOFF_W-1:0] moff;
        logic [DAY_W-1:0]  mlen;
        logic [DAY_W-1:0]  day;
    } t_s1;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [DAYS_W-1:0] y365;
        logic [22:0]       yy4;
        logic [QY_W-1:0]   q100;
        logic [16:0]       q400;
        logic [MOFF_W-1:0] moff;
        logic [DAY_W-1:0]  day;
    } t_s2;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [DAYS_W-1:0] days;
    } t_s3;

    typedef struct packed {
        logic             valid;
        logic             valid_res;
        logic [2:0]       weekday;
        logic [SEC_W-1:0] epoch_seconds;
    } t_res;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a year that starts in March.
    function automatic logic [MOFF_W-1:0] month_off(input logic [MON_W-1:0] m);
        logic [MOFF_W-1:0] off;
        case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

[sv/date_to_weekday_and_epoch.sv]
// Top level of the date to weekday and epoch pipeline.
// Depends on dte_pkg, dte_check, dte_year, dte_count and dte_scale.
`timescale 1ns / 1ps

// Checks a Gregorian date (year 1970..30000000) and returns the ISO weekday
// (1 = Monday .. 7 = Sunday) and the Unix time at midnight of that date, or all
// zeros with o_valid_res low for an invalid date. The block takes one
// transaction per cycle while o_stall is low, and each accepted input passes
// through the four register stages: range checks with the reciprocal
// product for the division by 100, leap rule with the day-of-month check, the
// day-count sum, and the scaling by 86400 with the weekday residue. Stages that
// hold no transaction fill even while the output is stalled, so up to four
// transactions are held in flight. No state survives between dates.

module date_to_weekday_and_epoch
    import dte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [YEAR_W-1:0] i_year,
    input  logic [MON_W-1:0]  i_month,
    input  logic [DAY_W-1:0]  i_day,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_valid_res,
    output logic [2:0]        o_weekday,
    output logic [SEC_W-1:0]  o_epoch_seconds
);

    t_s1  s1;
    t_s2  s2;
    t_s3  s3;
    t_res res;

    logic en1;
    logic en2;
    logic en3;
    logic en4;

    // A stage loads when it is empty or its contents move on this cycle.
    assign en4 = !res.valid || !i_stall;
    assign en3 = !s3.valid || en4;
    assign en2 = !s2.valid || en3;
    assign en1 = !s1.valid || en2;

    assign o_stall = !en1;

    dte_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_valid (i_valid),
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_s1    (s1)
    );

    dte_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    dte_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_s2    (s2),
        .o_s3    (s3)
    );

    dte_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en4),
        .i_s3    (s3),
        .o_res   (res)
    );

    assign o_valid         = res.valid;
    assign o_valid_res     = res.valid_res;
    assign o_weekday       = res.weekday;
    assign o_epoch_seconds = res.epoch_seconds;

    // Upstream is held off only when every stage is full and the output is stalled.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && s1.valid && s2.valid && s3.valid))
        else $error("input stalled while the pipeline has room");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_weekday == 3'd0 && o_epoch_seconds == '0))
        else $error("invalid date carries a nonzero result");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> (o_weekday != 3'd0))
        else $error("valid date with weekday zero");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3.valid && en4) |=> o_valid)
        else $error("transaction lost between the last two stages");

endmodule

[sv/dte_check.sv]
// Stage one: range checks, month tables and the reciprocal product for the century split.
// Depends on dte_pkg.
`timescale 1ns / 1ps

module dte_check
    import dte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [YEAR_W-1:0] i_year,
    input  logic [MON_W-1:0]  i_month,
    input  logic [DAY_W-1:0]  i_day,
    output t_s1               o_s1
);

    t_s1 r_s1;
    t_s1 n_s1;

    always_comb begin
        n_s1.valid  = i_valid;
        n_s1.pre_ok = (i_year >= YEAR_MIN) && (i_year <= YEAR_MAX)
                   && (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC)
                   && (i_day != '0);
        // January and February belong to the previous March-based year.
        n_s1.early  = (i_month <= MONTH_FEB);
        n_s1.feb    = (i_month == MONTH_FEB);
        n_s1.year   = i_year;
        n_s1.prod   = PROD_W'(i_year) * PROD_W'(DIV100_MUL);
        n_s1.moff   = month_off(i_month);
        n_s1.mlen   = month_len(i_month);
        n_s1.day    = i_day;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

[sv/dte_year.sv]
// Stage two: century quotient, leap rule, day-of-month check and the 365-day product.
// Depends on dte_pkg.
`timescale 1ns / 1ps

module dte_year
    import dte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    t_s2 r_s2;
    t_s2 n_s2;

    logic [QY_W-1:0]   qy;
    logic [YEAR_W-1:0] qy100;
    logic              cent_zero;
    logic              leap;
    logic [YEAR_W-1:0] yy;
    logic [DAY_W:0]    day_lim;

    always_comb begin
        qy        = i_s1.prod[DIV100_SHIFT +: QY_W];
        qy100     = YEAR_W'(qy) * YEAR_W'(CENTURY);
        cent_zero = (i_s1.year == qy100);
        leap      = ((i_s1.year[1:0] == 2'b00) && !cent_zero)
                 || (cent_zero && (qy[1:0] == 2'b00));
        yy        = i_s1.year - YEAR_W'(i_s1.early);
        day_lim   = {1'b0, i_s1.mlen} + (DAY_W+1)'(i_s1.feb && leap);

        n_s2.valid = i_s1.valid;
        n_s2.ok    = i_s1.pre_ok && ({1'b0, i_s1.day} <= day_lim);
        n_s2.y365  = DAYS_W'(yy) * DAYS_PER_YEAR;
        n_s2.yy4   = yy[YEAR_W-1:2];
        // Stepping back one year crosses a century line only when the year ends in 00.
        n_s2.q100  = qy - QY_W'(i_s1.early && cent_zero);
        n_s2.q400  = n_s2.q100[QY_W-1:2];
        n_s2.moff  = i_s1.moff;
        n_s2.day   = i_s1.day;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

[sv/dte_count.sv]
// Stage three: sums the parts of the day count relative to 1970-01-01.
// Depends on dte_pkg.
`timescale 1ns / 1ps

module dte_count
    import dte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_s2  i_s2,
    output t_s3  o_s3
);

    t_s3 r_s3;
    t_s3 n_s3;

    always_comb begin
        n_s3.valid = i_s2.valid;
        n_s3.ok    = i_s2.ok;
        // The true count fits in the word for every valid date, so wraparound is harmless.
        n_s3.days  = i_s2.y365 + DAYS_W'(i_s2.yy4) + DAYS_W'(i_s2.q400)
                   - DAYS_W'(i_s2.q100) + DAYS_W'(i_s2.moff) + DAYS_W'(i_s2.day)
                   - EPOCH_DAY_OFFSET - DAYS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

[sv/dte_scale.sv]
// Stage four: scales the day count to seconds and reduces it modulo 7 for the weekday.
// Depends on dte_pkg; this register is the output register of the block.
`timescale 1ns / 1ps

module dte_scale
    import dte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_s3  i_s3,
    output t_res o_res
);

    t_res r_res;
    t_res n_res;

    logic [35:0]            days_pad;
    logic [5:0]             acc_a;
    logic [5:0]             acc_b;
    logic [6:0]             fold1;
    logic [3:0]             fold2;
    logic [3:0]             fold3;
    logic [2:0]             rem7;
    logic [2:0]             wday;
    logic [DAYS_W+9:0]      prod;

    // Since 8 is 1 modulo 7, summing the octal digits keeps the residue.
    always_comb begin
        days_pad = 36'(i_s3.days);
        acc_a    = '0;
        acc_b    = '0;
        for (int i = 0; i < 6; i++) begin
            acc_a = acc_a + 6'(days_pad[3*i +: 3]);
            acc_b = acc_b + 6'(days_pad[3*(i+6) +: 3]);
        end
        fold1 = 7'(acc_a) + 7'(acc_b);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]) + 4'(fold1[6]);
        fold3 = 4'(fold2[2:0]) + 4'(fold2[3]);
        rem7  = (fold3 >= 4'd7) ? 3'(fold3 - 4'd7) : fold3[2:0];
        // 1970-01-01 was a Thursday.
        wday  = (rem7 <= 3'd3) ? (rem7 + 3'd4) : (rem7 - 3'd3);
        prod  = (DAYS_W+10)'(i_s3.days) * (DAYS_W+10)'(SEC_MUL);

        n_res.valid         = i_s3.valid;
        n_res.valid_res     = i_s3.ok;
        n_res.weekday       = i_s3.ok ? wday : 3'd0;
        n_res.epoch_seconds = i_s3.ok ? SEC_W'({prod, {SEC_SHIFT{1'b0}}}) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[sim/tb_date_to_weekday_and_epoch.sv]
// Self-checking testbench for date_to_weekday_and_epoch: directed edge dates, then random dates.
// Depends on dte_pkg for field widths and year limits; predicts every result internally.
`timescale 1ns / 1ps

module tb_date_to_weekday_and_epoch;
    import dte_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic             valid_res;
        logic [2:0]       weekday;
        logic [SEC_W-1:0] epoch_seconds;
    } t_date_result;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [YEAR_W-1:0] i_year  = '0;
    logic [MON_W-1:0]  i_month = '0;
    logic [DAY_W-1:0]  i_day   = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_valid_res;
    logic [2:0]        o_weekday;
    logic [SEC_W-1:0]  o_epoch_seconds;

    t_date_result pending_results[$];
    int           mismatch_count = 0;
    // Chance in four of a burst per free cycle; zero turns idling off.
    int           idle_odds      = 0;

    date_to_weekday_and_epoch dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_year          (i_year),
        .i_month         (i_month),
        .i_day           (i_day),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_valid_res     (o_valid_res),
        .o_weekday       (o_weekday),
        .o_epoch_seconds (o_epoch_seconds)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y,
                                                  input int unsigned m);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic t_date_result calc_weekday_epoch(input logic [YEAR_W-1:0] y,
                                                        input logic [MON_W-1:0] m,
                                                        input logic [DAY_W-1:0] d);
        t_date_result      r;
        int unsigned       mlen;
        longint            zy, zm, cent, yoc, w;
        longint unsigned   mar_idx, ey, days;
        r    = '0;
        mlen = days_in_month(32'(y), 32'(m));
        if (y < YEAR_MIN || y > YEAR_MAX || mlen == 0 || d == 0 || d > mlen)
            return r;
        // Zeller: January and February belong to the previous year as months 13 and 14.
        zy = longint'(y);
        zm = longint'(m);
        if (zm <= 2) begin
            zm = zm + 12;
            zy = zy - 1;
        end
        cent = zy / 100;
        yoc  = zy % 100;
        w    = yoc + yoc / 4 + cent / 4 - 2 * cent + (13 * (zm + 1)) / 5 + longint'(d) - 1;
        w    = ((w % 7) + 7) % 7;
        if (w == 0)
            w = 7;
        // Day count with March as month index 0.
        mar_idx = (longint'(m) + 9) % 12;
        ey      = longint'(y) - mar_idx / 10;
        days    = 365 * ey + ey / 4 - ey / 100 + ey / 400 + (mar_idx * 306 + 5) / 10
                + longint'(d) - 1 - 719468;
        r.valid_res     = 1'b1;
        r.weekday       = w[2:0];
        r.epoch_seconds = SEC_W'(days * 86400);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Drives one date and returns at the edge that accepts it; valid stays high.
    // Values wider than a field keep only the field's low bits.
    task automatic send_date(input int unsigned y, input int unsigned m,
                             input int unsigned d);
        int                gap;
        logic [YEAR_W-1:0] y_bits;
        logic [MON_W-1:0]  m_bits;
        logic [DAY_W-1:0]  d_bits;
        y_bits = YEAR_W'(y);
        m_bits = MON_W'(m);
        d_bits = DAY_W'(d);
        if (idle_odds > 0 && $urandom_range(0, 3) < idle_odds) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_year  <= y_bits;
        i_month <= m_bits;
        i_day   <= d_bits;
        pending_results.push_back(calc_weekday_epoch(y_bits, m_bits, d_bits));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic int unsigned rand_valid_year();
        int unsigned y;
        case ($urandom_range(0, 3))
            0:       y = $urandom_range(1970, 2600);
            1:       y = $urandom_range(1970, 30000000);
            // Century years and the years just after them exercise the leap rule.
            2:       y = $urandom_range(20, 299999) * 100 + $urandom_range(0, 1);
            default: y = $urandom_range(29999000, 30000000);
        endcase
        return y;
    endfunction

    task automatic send_valid_date();
        int unsigned y;
        int unsigned m;
        y = rand_valid_year();
        m = $urandom_range(1, 12);
        send_date(y, m, $urandom_range(1, days_in_month(y, m)));
    endtask

    task automatic send_broken_date();
        int unsigned y;
        int unsigned m;
        y = rand_valid_year();
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 4))
            0: send_date($urandom(), $urandom(), $urandom());
            1: send_date(y, m, days_in_month(y, m) + 1);
            2: send_date(y, m, 0);
            3: send_date($urandom_range(0, 1) ? $urandom_range(0, 1969)
                                              : $urandom_range(30000001, 33554431),
                         m, 1);
            default: send_date(y, $urandom_range(0, 1) ? 0 : $urandom_range(13, 15),
                               $urandom());
        endcase
    endtask

    task automatic test_range_limits();
        idle_odds = 1;
        send_date(1970, 1, 1);
        send_date(30000000, 12, 31);
        send_date(1969, 12, 31);
        send_date(30000001, 1, 1);
        send_date(0, 0, 0);
        send_date(33554431, 15, 31);
        send_date(2024, 0, 15);
        send_date(2024, 13, 1);
        send_date(2024, 15, 31);
        send_date(2024, 5, 0);
        send_date(2024, 4, 31);
        send_date(2024, 1, 31);
        send_date(2024, 12, 31);
    endtask

    task automatic test_leap_rule();
        send_date(2024, 2, 29);
        send_date(2023, 2, 29);
        send_date(2024, 2, 30);
        send_date(2100, 2, 29);
        send_date(2000, 2, 29);
        send_date(2400, 2, 29);
        send_date(2000, 3, 1);
        send_date(1999, 12, 31);
        send_date(1970, 2, 28);
        send_date(29999999, 2, 28);
    endtask

    task automatic test_random_dates(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0)
                idle_odds = $urandom_range(0, 3);
            if ($urandom_range(0, 9) < 7)
                send_valid_date();
            else
                send_broken_date();
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_odds = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7)
                send_valid_date();
            else
                send_broken_date();
        end
    endtask

    // Output side: random stall bursts while idling is enabled.
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (idle_odds > 0 && $urandom_range(0, 3) < idle_odds) begin
                burst = $urandom_range(1, 8);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_date_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with no date outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res got %b want %b",
                                              o_valid_res, want.valid_res));
                if (o_weekday !== want.weekday)
                    report_mismatch($sformatf("weekday got %0d want %0d",
                                              o_weekday, want.weekday));
                if (o_epoch_seconds !== want.epoch_seconds)
                    report_mismatch($sformatf("epoch_seconds got %0d want %0d",
                                              o_epoch_seconds, want.epoch_seconds));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("tb_date_to_weekday_and_epoch: FAIL");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_range_limits();
        test_leap_rule();
        test_random_dates(1600);
        test_back_to_back(400);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_date_to_weekday_and_epoch: PASS");
        else
            $display("tb_date_to_weekday_and_epoch: FAIL");
        $finish;
    end

endmodule
